FILE: rtl/abp_pkg.sv
// ----------------------------------------------------------------------------
// abp_pkg
// Shared widths, fixed-point constants, register codes and the CORDIC
// arctangent table for the active Brownian particle step core.
// ----------------------------------------------------------------------------
package abp_pkg;

	// field widths
	localparam int IDX_W   = 10;
	localparam int POS_W   = 32;
	localparam int ANG_W   = 31;
	localparam int CFG_W   = 31;
	localparam int NOISE_W = 16;
	localparam int NSUM_W  = 17;

	// default sizing
	localparam int PARTICLES_DEF    = 1024;
	localparam int CORDIC_STEPS_DEF = 24;

	// CORDIC datapath width (Q2.30 / Q3.28 with headroom)
	localparam int CW = 34;

	// pipelined divider: magnitude of time_step * velocity fits 62 bits
	localparam int DIV_STAGES = 62;
	// pipelined square root of a 48-bit radicand, one result bit a stage
	localparam int SQRT_STAGES = 24;

	localparam logic signed [CW-1:0] Q28_PI      = 34'sd843314857;
	localparam logic signed [CW-1:0] Q28_HALF_PI = 34'sd421657428;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam longint               Q28_PI_L     = 843314857;
	localparam longint               Q28_TWO_PI_L = 1686629713;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_INV_GAMMA  = 3'd0,
		REG_SELF_SPEED = 3'd1,
		REG_TURN_RATE  = 3'd2,
		REG_TIME_STEP  = 3'd3,
		REG_XNOISE     = 3'd4,
		REG_ANOISE     = 3'd5,
		REG_NOISE_EN   = 3'd6
	} cfg_reg_t;

	// arctangent of 2^-i in Q3.28
	function automatic logic signed [CW-1:0] atan_q28(input int unsigned i);
		logic signed [CW-1:0] r;
		case (i)
			0:       r = 34'sd210828714;
			1:       r = 34'sd124459457;
			2:       r = 34'sd65760959;
			3:       r = 34'sd33381290;
			4:       r = 34'sd16755422;
			5:       r = 34'sd8385879;
			6:       r = 34'sd4193963;
			7:       r = 34'sd2097109;
			8:       r = 34'sd1048571;
			9:       r = 34'sd524287;
			10:      r = 34'sd262144;
			11:      r = 34'sd131072;
			12:      r = 34'sd65536;
			13:      r = 34'sd32768;
			14:      r = 34'sd16384;
			15:      r = 34'sd8192;
			16:      r = 34'sd4096;
			17:      r = 34'sd2048;
			18:      r = 34'sd1024;
			19:      r = 34'sd512;
			20:      r = 34'sd256;
			21:      r = 34'sd128;
			22:      r = 34'sd64;
			23:      r = 34'sd32;
			24:      r = 34'sd16;
			25:      r = 34'sd8;
			26:      r = 34'sd4;
			27:      r = 34'sd2;
			28:      r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// saturate a signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/abp_noise_mem.sv
// ----------------------------------------------------------------------------
// abp_noise_mem
// Per-particle store of the previous noise word: one write port, one read
// port with registered read data (read-before-write on the same address).
// ----------------------------------------------------------------------------
module abp_noise_mem import abp_pkg::*; #(
	parameter int PARTICLES = PARTICLES_DEF
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [$clog2(PARTICLES)-1:0]   rd_addr,
	output logic [3*NOISE_W-1:0]           rd_data,
	input  logic                           wr_en,
	input  logic [$clog2(PARTICLES)-1:0]   wr_addr,
	input  logic [3*NOISE_W-1:0]           wr_data
);

	logic [3*NOISE_W-1:0] mem [PARTICLES];
	logic [3*NOISE_W-1:0] rd_q;

	// write the fresh word, read the old one
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: rtl/abp_cordic.sv
// ----------------------------------------------------------------------------
// abp_cordic
// Rotation-mode CORDIC, one iteration per pipeline stage. Takes a
// pre-rotated angle and a negate flag, returns cos and sin in Q2.30.
// ----------------------------------------------------------------------------
module abp_cordic import abp_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] ang,
	input  logic                 neg,
	output logic signed [CW-1:0] cos_o,
	output logic signed [CW-1:0] sin_o
);

	logic signed [CW-1:0] x_q [STEPS];
	logic signed [CW-1:0] y_q [STEPS];
	logic signed [CW-1:0] z_q [STEPS-1];
	logic [STEPS-1:0]     neg_q;

	genvar i;
	generate
		for (i = 0; i < STEPS; i++) begin : g_stage
			logic signed [CW-1:0] xi, yi, zi;
			logic                 ni;

			if (i == 0) begin : g_first
				assign xi = CORDIC_GAIN;
				assign yi = '0;
				assign zi = ang;
				assign ni = neg;
			end else begin : g_next
				assign xi = x_q[i-1];
				assign yi = y_q[i-1];
				assign zi = z_q[i-1];
				assign ni = neg_q[i-1];
			end

			// rotate toward zero residual angle
			always_ff @(posedge clk) begin
				if (en) begin
					if (zi >= 0) begin
						x_q[i] <= xi - (yi >>> i);
						y_q[i] <= yi + (xi >>> i);
					end else begin
						x_q[i] <= xi + (yi >>> i);
						y_q[i] <= yi - (xi >>> i);
					end
					neg_q[i] <= ni;
				end
			end

			if (i < STEPS - 1) begin : g_z
				always_ff @(posedge clk) begin
					if (en) begin
						if (zi >= 0) begin
							z_q[i] <= zi - atan_q28(i);
						end else begin
							z_q[i] <= zi + atan_q28(i);
						end
					end
				end
			end
		end
	endgenerate

	// undo the half-turn pre-rotation
	assign cos_o = neg_q[STEPS-1] ? -x_q[STEPS-1] : x_q[STEPS-1];
	assign sin_o = neg_q[STEPS-1] ? -y_q[STEPS-1] : y_q[STEPS-1];

endmodule

FILE: rtl/abp_div.sv
// ----------------------------------------------------------------------------
// abp_div
// Pipelined restoring divider, one quotient bit per stage. Signed dividend,
// positive divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module abp_div import abp_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DIV_STAGES:0]   num,
	input  logic [CFG_W-1:0]             den,
	output logic signed [DIV_STAGES:0]   quo
);

	localparam int LAST = DIV_STAGES - 1;

	logic [DIV_STAGES-1:0] nq_q  [DIV_STAGES];
	logic [CFG_W-1:0]      rem_q [DIV_STAGES-1];
	logic [CFG_W-1:0]      den_q [DIV_STAGES-1];
	logic [DIV_STAGES-1:0] neg_q;
	logic [DIV_STAGES:0]   mag;
	logic signed [DIV_STAGES:0] qs;

	assign mag = (num < 0) ? -num : num;

	genvar i;
	generate
		for (i = 0; i < DIV_STAGES; i++) begin : g_stage
			logic [DIV_STAGES-1:0] nqi;
			logic [CFG_W-1:0]      remi, deni;
			logic                  negi;
			logic [CFG_W:0]        t, diff;
			logic                  ge;

			if (i == 0) begin : g_first
				assign nqi  = mag[DIV_STAGES-1:0];
				assign remi = '0;
				assign deni = den;
				assign negi = num[DIV_STAGES];
			end else begin : g_next
				assign nqi  = nq_q[i-1];
				assign remi = rem_q[i-1];
				assign deni = den_q[i-1];
				assign negi = neg_q[i-1];
			end

			// shift in one dividend bit, subtract when it fits
			assign t    = {remi, nqi[DIV_STAGES-1]};
			assign diff = t - {1'b0, deni};
			assign ge   = (t >= {1'b0, deni});

			always_ff @(posedge clk) begin
				if (en) begin
					nq_q[i]  <= {nqi[DIV_STAGES-2:0], ge};
					neg_q[i] <= negi;
				end
			end

			if (i < LAST) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_q[i] <= ge ? diff[CFG_W-1:0] : t[CFG_W-1:0];
						den_q[i] <= deni;
					end
				end
			end
		end
	endgenerate

	// restore the sign
	assign qs  = $signed({1'b0, nq_q[LAST]});
	assign quo = neg_q[LAST] ? -qs : qs;

endmodule

FILE: rtl/abp_isqrt.sv
// ----------------------------------------------------------------------------
// abp_isqrt
// Pipelined integer square root (floor), two radicand bits and one root bit
// per stage.
// ----------------------------------------------------------------------------
module abp_isqrt import abp_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic [2*SQRT_STAGES-1:0]   n,
	output logic [SQRT_STAGES-1:0]     root
);

	localparam int NW   = 2 * SQRT_STAGES;
	localparam int RW   = SQRT_STAGES + 3;
	localparam int LAST = SQRT_STAGES - 1;

	logic [NW-1:0]          nb_q   [SQRT_STAGES-1];
	logic [RW-1:0]          rem_q  [SQRT_STAGES-1];
	logic [SQRT_STAGES-1:0] root_q [SQRT_STAGES];

	genvar i;
	generate
		for (i = 0; i < SQRT_STAGES; i++) begin : g_stage
			logic [NW-1:0]          nbi;
			logic [RW-1:0]          remi, sh, trial;
			logic [SQRT_STAGES-1:0] rooti;
			logic                   ge;

			if (i == 0) begin : g_first
				assign nbi   = n;
				assign remi  = '0;
				assign rooti = '0;
			end else begin : g_next
				assign nbi   = nb_q[i-1];
				assign remi  = rem_q[i-1];
				assign rooti = root_q[i-1];
			end

			// bring down the next bit pair and try 4*root+1
			assign sh    = {remi[RW-3:0], nbi[NW-1:NW-2]};
			assign trial = {1'b0, rooti, 2'b01};
			assign ge    = (sh >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					root_q[i] <= {rooti[SQRT_STAGES-2:0], ge};
				end
			end

			if (i < LAST) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_q[i] <= ge ? (sh - trial) : sh;
						nb_q[i]  <= {nbi[NW-3:0], 2'b00};
					end
				end
			end
		end
	endgenerate

	assign root = root_q[LAST];

endmodule

FILE: rtl/active_brownian_baoab_step_core.sv
// ----------------------------------------------------------------------------
// active_brownian_baoab_step_core
// One BAOAB step for an active Brownian particle per cmd 1 input word.
//
// Input channel (item_valid / item_stall): cmd 0 stores three noise samples
// for particle_index and gives no result; cmd 1 steps the particle and gives
// one result word (out-of-group particles pass position and angle through
// with zero velocity). Output channel (result_valid / result_stall) carries
// the new position, heading and deterministic velocity.
// A new word is taken every cycle while item_stall is low. Results pass
// through the CORDIC stages and the 62-stage divider for the drift term.
// Stored noise is read and rewritten at acceptance, so back-to-back words
// for one particle see each other. When result_stall holds a waiting
// result, the whole pipeline freezes and item_stall rises in the same
// cycle; nothing is dropped. Reset empties the pipeline and loads the
// register defaults; the noise store is not cleared and must be loaded
// before a particle is stepped. Configuration (cfg_valid / cfg_ready,
// always ready) must be written only while idle; the core does not enforce it.
// ----------------------------------------------------------------------------
module active_brownian_baoab_step_core import abp_pkg::*; #(
	parameter int PARTICLES    = PARTICLES_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic                      cmd,
	input  logic [IDX_W-1:0]          particle_index,
	input  logic                      in_group,
	input  logic signed [POS_W-1:0]   force_x,
	input  logic signed [POS_W-1:0]   force_y,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [ANG_W-1:0]   angle,
	input  logic [CFG_W-1:0]          mass,
	input  logic signed [NOISE_W-1:0] noise_x,
	input  logic signed [NOISE_W-1:0] noise_y,
	input  logic signed [NOISE_W-1:0] noise_angle,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [POS_W-1:0]   new_pos_x,
	output logic signed [POS_W-1:0]   new_pos_y,
	output logic signed [ANG_W-1:0]   new_angle,
	output logic signed [POS_W-1:0]   vel_x,
	output logic signed [POS_W-1:0]   vel_y,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [31:0]               cfg_data
);

	localparam int AW     = $clog2(PARTICLES);
	localparam int NT_DLY = DIV_STAGES - SQRT_STAGES - 2;

	typedef struct packed {
		logic                      v;
		logic                      res;
		logic                      ok;
		logic                      grp;
		logic signed [POS_W-1:0]   fx;
		logic signed [POS_W-1:0]   fy;
		logic signed [POS_W-1:0]   px;
		logic signed [POS_W-1:0]   py;
		logic signed [ANG_W-1:0]   ang;
		logic [CFG_W-1:0]          mass;
		logic signed [NOISE_W-1:0] nx;
		logic signed [NOISE_W-1:0] ny;
		logic signed [NOISE_W-1:0] na;
	} s1_t;

	typedef struct packed {
		logic                     v;
		logic                     res;
		logic                     grp;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [ANG_W-1:0]  ang;
		logic [CFG_W-1:0]         mass;
		logic signed [NSUM_W-1:0] nsx;
		logic signed [NSUM_W-1:0] nsy;
		logic signed [62:0]       fxg;
		logic signed [62:0]       fyg;
		logic signed [62:0]       trp;
		logic signed [47:0]       anp;
	} s2_t;

	typedef struct packed {
		logic                     v;
		logic                     res;
		logic                     grp;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [ANG_W-1:0]  ang;
		logic [CFG_W-1:0]         mass;
		logic signed [NSUM_W-1:0] nsx;
		logic signed [NSUM_W-1:0] nsy;
		logic signed [62:0]       fxg;
		logic signed [62:0]       fyg;
		logic signed [60:0]       angsum;
	} side1_t;

	typedef struct packed {
		logic                     v;
		logic                     res;
		logic                     grp;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic [CFG_W-1:0]         mass;
		logic signed [NSUM_W-1:0] nsx;
		logic signed [NSUM_W-1:0] nsy;
		logic signed [62:0]       fxg;
		logic signed [62:0]       fyg;
		logic signed [CW-1:0]     sscx;
		logic signed [CW-1:0]     sscy;
		logic signed [ANG_W-1:0]  nang;
	} sm_t;

	typedef struct packed {
		logic                    v;
		logic                    res;
		logic                    grp;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [ANG_W-1:0] nang;
		logic signed [POS_W-1:0] vx;
		logic signed [POS_W-1:0] vy;
	} side2_t;

	typedef struct packed {
		logic signed [NSUM_W-1:0] nsx;
		logic signed [NSUM_W-1:0] nsy;
	} nsum_t;

	typedef struct packed {
		logic signed [44:0] ntx;
		logic signed [44:0] nty;
	} nterm_t;

	// configuration registers
	logic [CFG_W-1:0]        inv_gamma_q;
	logic [CFG_W-1:0]        self_speed_q;
	logic signed [31:0]      turn_rate_q;
	logic [CFG_W-1:0]        time_step_q;
	logic [CFG_W-1:0]        xnoise_q;
	logic [CFG_W-1:0]        anoise_q;
	logic                    noise_en_q;

	logic                    adv;
	logic                    accept;
	logic [31:0]             idx32;
	logic                    idx_ok;
	logic [3*NOISE_W-1:0]    rd_word;

	s1_t                     st_s1;
	s2_t                     st_s2;
	side1_t                  st_s3;
	logic signed [CW-1:0]    rot_s3;
	logic                    neg_s3;
	side1_t                  side1_q [CORDIC_STEPS];
	sm_t                     st_sm;
	side2_t                  st_sv;
	logic [CFG_W-1:0]        mass_sv;
	logic signed [NSUM_W-1:0] nsx_sv, nsy_sv;
	side2_t                  side2_q [DIV_STAGES+1];
	logic signed [62:0]      tvx_st, tvy_st;
	logic [CFG_W-1:0]        mass_st;
	nsum_t                   ns_st;
	nsum_t                   nsd_q [SQRT_STAGES];
	logic [38:0]             g_g1;
	nsum_t                   ns_g1;
	nterm_t                  nt_g2;
	nterm_t                  nt_q [NT_DLY];

	logic signed [CW-1:0]    cos_w, sin_w;
	logic [SQRT_STAGES-1:0]  root_w;
	logic signed [DIV_STAGES:0] qx_w, qy_w;

	// result register
	logic                    result_valid_q;
	logic signed [POS_W-1:0] new_pos_x_q, new_pos_y_q, vel_x_q, vel_y_q;
	logic signed [ANG_W-1:0] new_angle_q;

	// ------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------
	assign adv        = !result_valid_q || !result_stall;
	assign accept     = item_valid && adv;
	assign item_stall = !adv;
	assign cfg_ready  = 1'b1;

	// ------------------------------------------------------------------
	// configuration write
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_gamma_q  <= 31'd65536;
			self_speed_q <= '0;
			turn_rate_q  <= '0;
			time_step_q  <= 31'd65;
			xnoise_q     <= '0;
			anoise_q     <= '0;
			noise_en_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_INV_GAMMA:  inv_gamma_q  <= cfg_data[CFG_W-1:0];
				REG_SELF_SPEED: self_speed_q <= cfg_data[CFG_W-1:0];
				REG_TURN_RATE:  turn_rate_q  <= cfg_data;
				REG_TIME_STEP:  time_step_q  <= cfg_data[CFG_W-1:0];
				REG_XNOISE:     xnoise_q     <= cfg_data[CFG_W-1:0];
				REG_ANOISE:     anoise_q     <= cfg_data[CFG_W-1:0];
				REG_NOISE_EN:   noise_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// noise store: read old word, write fresh word at acceptance
	// ------------------------------------------------------------------
	assign idx32  = 32'(particle_index);
	assign idx_ok = (idx32 < 32'(PARTICLES));

	abp_noise_mem #(.PARTICLES(PARTICLES)) u_mem (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (idx32[AW-1:0]),
		.rd_data (rd_word),
		.wr_en   (accept && idx_ok && (!cmd || in_group)),
		.wr_addr (idx32[AW-1:0]),
		.wr_data ({noise_angle, noise_y, noise_x})
	);

	// ------------------------------------------------------------------
	// s1: capture the word
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (adv) begin
			st_s1.v    <= accept;
			st_s1.res  <= cmd;
			st_s1.ok   <= idx_ok;
			st_s1.grp  <= in_group;
			st_s1.fx   <= force_x;
			st_s1.fy   <= force_y;
			st_s1.px   <= pos_x;
			st_s1.py   <= pos_y;
			st_s1.ang  <= angle;
			st_s1.mass <= mass;
			st_s1.nx   <= noise_x;
			st_s1.ny   <= noise_y;
			st_s1.na   <= noise_angle;
		end
	end

	// ------------------------------------------------------------------
	// s2: noise sums and the products that need no heading
	// ------------------------------------------------------------------
	logic signed [NOISE_W-1:0] sx_w, sy_w, sa_w;
	logic signed [NSUM_W-1:0]  nsa_w;

	assign sx_w  = st_s1.ok ? $signed(rd_word[NOISE_W-1:0])           : '0;
	assign sy_w  = st_s1.ok ? $signed(rd_word[2*NOISE_W-1:NOISE_W])   : '0;
	assign sa_w  = st_s1.ok ? $signed(rd_word[3*NOISE_W-1:2*NOISE_W]) : '0;
	assign nsa_w = NSUM_W'(st_s1.na) + NSUM_W'(sa_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else if (adv) begin
			st_s2.v    <= st_s1.v;
			st_s2.res  <= st_s1.res;
			st_s2.grp  <= st_s1.grp;
			st_s2.px   <= st_s1.px;
			st_s2.py   <= st_s1.py;
			st_s2.ang  <= st_s1.ang;
			st_s2.mass <= (st_s1.mass == '0) ? CFG_W'(1) : st_s1.mass;
			st_s2.nsx  <= NSUM_W'(st_s1.nx) + NSUM_W'(sx_w);
			st_s2.nsy  <= NSUM_W'(st_s1.ny) + NSUM_W'(sy_w);
			st_s2.fxg  <= st_s1.fx * $signed({1'b0, inv_gamma_q});
			st_s2.fyg  <= st_s1.fy * $signed({1'b0, inv_gamma_q});
			st_s2.trp  <= turn_rate_q * $signed({1'b0, time_step_q});
			st_s2.anp  <= $signed({1'b0, anoise_q}) * nsa_w;
		end
	end

	// ------------------------------------------------------------------
	// s3: raw new heading and the half-turn pre-rotation
	// ------------------------------------------------------------------
	logic signed [CW-1:0] a_w;

	assign a_w = CW'(st_s2.ang);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s3  <= '0;
			rot_s3 <= '0;
			neg_s3 <= 1'b0;
		end else if (adv) begin
			st_s3.v      <= st_s2.v;
			st_s3.res    <= st_s2.res;
			st_s3.grp    <= st_s2.grp;
			st_s3.px     <= st_s2.px;
			st_s3.py     <= st_s2.py;
			st_s3.ang    <= st_s2.ang;
			st_s3.mass   <= st_s2.mass;
			st_s3.nsx    <= st_s2.nsx;
			st_s3.nsy    <= st_s2.nsy;
			st_s3.fxg    <= st_s2.fxg;
			st_s3.fyg    <= st_s2.fyg;
			st_s3.angsum <= 61'(st_s2.ang) + 61'($signed(st_s2.trp[62:4]))
			              + 61'(st_s2.anp);
			if (a_w > Q28_HALF_PI) begin
				rot_s3 <= a_w - Q28_PI;
				neg_s3 <= 1'b1;
			end else if (a_w < -Q28_HALF_PI) begin
				rot_s3 <= a_w + Q28_PI;
				neg_s3 <= 1'b1;
			end else begin
				rot_s3 <= a_w;
				neg_s3 <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// cos/sin of the heading, side data delayed alongside
	// ------------------------------------------------------------------
	abp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk   (clk),
		.en    (adv),
		.ang   (rot_s3),
		.neg   (neg_s3),
		.cos_o (cos_w),
		.sin_o (sin_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CORDIC_STEPS; k++) side1_q[k] <= '0;
		end else if (adv) begin
			side1_q[0] <= st_s3;
			for (int k = 1; k < CORDIC_STEPS; k++) side1_q[k] <= side1_q[k-1];
		end
	end

	// ------------------------------------------------------------------
	// sm: self-propulsion products, wrap and clamp the heading
	// ------------------------------------------------------------------
	function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [60:0] a);
		logic signed [60:0] w;
		logic signed [ANG_W-1:0] r;
		w = a;
		if (w > 61'(Q28_PI_L)) w = w - 61'(Q28_TWO_PI_L);
		if (w < -61'(Q28_PI_L)) w = w + 61'(Q28_TWO_PI_L);
		if (w > 61'sd1073741823) begin
			r = 31'sh3FFFFFFF;
		end else if (w < -61'sd1073741824) begin
			r = 31'sh40000000;
		end else begin
			r = w[ANG_W-1:0];
		end
		return r;
	endfunction

	side1_t             sd_w;
	logic signed [63:0] sscx_w, sscy_w;

	assign sd_w   = side1_q[CORDIC_STEPS-1];
	assign sscx_w = $signed({1'b0, self_speed_q}) * cos_w;
	assign sscy_w = $signed({1'b0, self_speed_q}) * sin_w;

	// out-of-group words carry the input heading through unchanged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_sm <= '0;
		end else if (adv) begin
			st_sm.v    <= sd_w.v;
			st_sm.res  <= sd_w.res;
			st_sm.grp  <= sd_w.grp;
			st_sm.px   <= sd_w.px;
			st_sm.py   <= sd_w.py;
			st_sm.mass <= sd_w.mass;
			st_sm.nsx  <= sd_w.nsx;
			st_sm.nsy  <= sd_w.nsy;
			st_sm.fxg  <= sd_w.fxg;
			st_sm.fyg  <= sd_w.fyg;
			st_sm.sscx <= sscx_w[63:30];
			st_sm.sscy <= sscy_w[63:30];
			st_sm.nang <= sd_w.grp ? wrap_angle(sd_w.angsum) : sd_w.ang;
		end
	end

	// ------------------------------------------------------------------
	// sv: deterministic velocity, saturated
	// ------------------------------------------------------------------
	logic signed [47:0] vsx_w, vsy_w;

	assign vsx_w = 48'($signed(st_sm.fxg[62:16])) + 48'(st_sm.sscx);
	assign vsy_w = 48'($signed(st_sm.fyg[62:16])) + 48'(st_sm.sscy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_sv <= '0;
		end else if (adv) begin
			st_sv.v    <= st_sm.v;
			st_sv.res  <= st_sm.res;
			st_sv.grp  <= st_sm.grp;
			st_sv.px   <= st_sm.px;
			st_sv.py   <= st_sm.py;
			st_sv.nang <= st_sm.nang;
			st_sv.vx   <= sat32(64'(vsx_w));
			st_sv.vy   <= sat32(64'(vsy_w));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mass_sv <= st_sm.mass;
			nsx_sv  <= st_sm.nsx;
			nsy_sv  <= st_sm.nsy;
		end
	end

	// ------------------------------------------------------------------
	// st: drift numerators, start of divider and root windows
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			tvx_st      <= $signed({1'b0, time_step_q}) * st_sv.vx;
			tvy_st      <= $signed({1'b0, time_step_q}) * st_sv.vy;
			mass_st     <= mass_sv;
			ns_st.nsx   <= nsx_sv;
			ns_st.nsy   <= nsy_sv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) side2_q[k] <= '0;
		end else if (adv) begin
			side2_q[0] <= st_sv;
			for (int k = 1; k <= DIV_STAGES; k++) side2_q[k] <= side2_q[k-1];
		end
	end

	// side2_q[0] is loaded together with tvx_st; the quotient, after the divider's
	// stages, comes out in step with side2_q[DIV_STAGES]
	abp_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (tvx_st),
		.den (mass_st),
		.quo (qx_w)
	);

	abp_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (tvy_st),
		.den (mass_st),
		.quo (qy_w)
	);

	// ------------------------------------------------------------------
	// noise gain sqrt(mass) * xnoise_scale and the noise terms
	// ------------------------------------------------------------------
	abp_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.n    ({1'b0, mass_st, 16'd0}),
		.root (root_w)
	);

	logic [54:0]        gp_w;
	logic signed [56:0] ntx_w, nty_w;

	assign gp_w  = root_w * xnoise_q;
	assign ntx_w = $signed({1'b0, g_g1}) * ns_g1.nsx;
	assign nty_w = $signed({1'b0, g_g1}) * ns_g1.nsy;

	always_ff @(posedge clk) begin
		if (adv) begin
			nsd_q[0] <= ns_st;
			for (int k = 1; k < SQRT_STAGES; k++) nsd_q[k] <= nsd_q[k-1];
			g_g1      <= gp_w[54:16];
			ns_g1     <= nsd_q[SQRT_STAGES-1];
			nt_g2.ntx <= noise_en_q ? ntx_w[56:12] : '0;
			nt_g2.nty <= noise_en_q ? nty_w[56:12] : '0;
			nt_q[0]   <= nt_g2;
			for (int k = 1; k < NT_DLY; k++) nt_q[k] <= nt_q[k-1];
		end
	end

	// ------------------------------------------------------------------
	// final sum, saturate, result register
	// ------------------------------------------------------------------
	side2_t             fin_w;
	nterm_t             ntf_w;
	logic signed [63:0] npx_w, npy_w;

	assign fin_w = side2_q[DIV_STAGES];
	assign ntf_w = nt_q[NT_DLY-1];
	assign npx_w = 64'(fin_w.px) + 64'(qx_w) + 64'(ntf_w.ntx);
	assign npy_w = 64'(fin_w.py) + 64'(qy_w) + 64'(ntf_w.nty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= fin_w.v && fin_w.res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fin_w.grp) begin
				new_pos_x_q <= sat32(npx_w);
				new_pos_y_q <= sat32(npy_w);
				vel_x_q     <= fin_w.vx;
				vel_y_q     <= fin_w.vy;
			end else begin
				new_pos_x_q <= fin_w.px;
				new_pos_y_q <= fin_w.py;
				vel_x_q     <= '0;
				vel_y_q     <= '0;
			end
			new_angle_q <= fin_w.nang;
		end
	end

	assign result_valid = result_valid_q;
	assign new_pos_x    = new_pos_x_q;
	assign new_pos_y    = new_pos_y_q;
	assign new_angle    = new_angle_q;
	assign vel_x        = vel_x_q;
	assign vel_y        = vel_y_q;

endmodule
